### rtl/core/bar_pkg.sv
package bar_pkg;

	localparam int NUM_REGS = 8;
	localparam int ADDR_W   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int IDX_W    = 3;
	localparam int DATA_W   = 8;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [DATA_W-1:0] data_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [3:0] {
		OP_ADDI = 4'd0,
		OP_ADDR = 4'd1,
		OP_ANDI = 4'd2,
		OP_ANDR = 4'd3,
		OP_ORI  = 4'd4,
		OP_ORR  = 4'd5,
		OP_XORI = 4'd6,
		OP_XORR = 4'd7,
		OP_NOT  = 4'd8,
		OP_SUBI = 4'd9,
		OP_SUBR = 4'd10,
		OP_SHLI = 4'd11,
		OP_SHLR = 4'd12,
		OP_SHRI = 4'd13,
		OP_SHRR = 4'd14
	} op_t;

	typedef struct packed {
		logic [3:0] req_type;
		data_t      imm_value;
		idx_t       src_index;
		idx_t       dst_index;
	} req_t;

	function automatic logic idx_in_range(input idx_t idx);
		return ({{(9-IDX_W){1'b0}}, idx} < 9'(NUM_REGS));
	endfunction

endpackage

### rtl/core/bar_req_if.sv
interface bar_req_if;
	logic                  valid;
	logic                  ready;
	logic [3:0]            req_type;
	bar_pkg::data_t        imm_value;
	bar_pkg::idx_t         src_index;
	bar_pkg::idx_t         dst_index;

	modport source (output valid, output req_type, output imm_value,
		output src_index, output dst_index, input ready);
	modport sink (input valid, input req_type, input imm_value,
		input src_index, input dst_index, output ready);
endinterface

### rtl/core/bar_res_if.sv
interface bar_res_if;
	logic                  valid;
	logic                  ready;
	bar_pkg::idx_t         written_index;
	bar_pkg::data_t        written_value;

	modport source (output valid, output written_index, output written_value,
		input ready);
	modport sink (input valid, input written_index, input written_value,
		output ready);
endinterface

### rtl/core/byte_alu_with_register_file.sv
// channel | dir | payload                                    | handshake
// req     | in  | req_type, imm_value, src_index, dst_index  | valid/ready
// res     | out | written_index, written_value               | valid/ready
//
// One request per cycle unless the output stalls: the register file is read at accept,
// the result is computed and written back in execute, and leaves via an output register.
// A same-cycle write to a register being read is forwarded.
// Reset (arst_n low) clears all valid bits, so every register reads zero.
// A stalled output holds the execute stage, which holds the request side.
module byte_alu_with_register_file (
	input  logic      clk,
	input  logic      arst_n,
	bar_req_if.sink   req,
	bar_res_if.source res
);
	import bar_pkg::*;

	data_t         regs_q [NUM_REGS];
	logic [NUM_REGS-1:0] vld_q;

	logic          valid_s1;
	req_t          req_s1;
	data_t         rd_d_s1;
	data_t         rd_s_s1;
	logic          ok_d_s1;
	logic          ok_s_s1;
	logic          fwd_d_s1;
	logic          fwd_s_s1;
	data_t         fwd_v_s1;

	logic          out_valid_q;
	idx_t          out_idx_q;
	data_t         out_val_q;

	logic          fire;
	logic          accept;
	logic          op_ok;
	logic          wr_en;
	data_t         d_val;
	data_t         s_val;
	data_t         result;
	addr_t         wr_addr;
	addr_t         rd_d_addr;
	addr_t         rd_s_addr;

	assign fire      = valid_s1 && (!out_valid_q || res.ready);
	assign req.ready = !valid_s1 || fire;
	assign accept    = req.valid && req.ready;
	assign wr_en     = fire && op_ok && idx_in_range(req_s1.dst_index);
	assign wr_addr   = ADDR_W'(req_s1.dst_index);
	assign rd_d_addr = ADDR_W'(req.dst_index);
	assign rd_s_addr = ADDR_W'(req.src_index);

	assign d_val = fwd_d_s1 ? fwd_v_s1 : (ok_d_s1 ? rd_d_s1 : '0);
	assign s_val = fwd_s_s1 ? fwd_v_s1 : (ok_s_s1 ? rd_s_s1 : '0);

	always_comb begin
		data_t amt;
		amt    = s_val;
		op_ok  = 1'b1;
		result = '0;
		case (req_s1.req_type)
			OP_ADDI: result = d_val + req_s1.imm_value;
			OP_ADDR: result = d_val + s_val;
			OP_ANDI: result = d_val & req_s1.imm_value;
			OP_ANDR: result = d_val & s_val;
			OP_ORI:  result = d_val | req_s1.imm_value;
			OP_ORR:  result = d_val | s_val;
			OP_XORI: result = d_val ^ req_s1.imm_value;
			OP_XORR: result = d_val ^ s_val;
			OP_NOT:  result = ~d_val;
			OP_SUBI: result = d_val - req_s1.imm_value;
			OP_SUBR: result = d_val - s_val;
			OP_SHLI: begin
				amt    = req_s1.imm_value;
				result = (amt >= 8'd8) ? '0 : data_t'(d_val << amt[2:0]);
			end
			OP_SHLR: result = (amt >= 8'd8) ? '0 : data_t'(d_val << amt[2:0]);
			OP_SHRI: begin
				amt    = req_s1.imm_value;
				result = (amt >= 8'd8) ? '0 : data_t'(d_val >> amt[2:0]);
			end
			OP_SHRR: result = (amt >= 8'd8) ? '0 : data_t'(d_val >> amt[2:0]);
			default: op_ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			regs_q[wr_addr] <= result;
		end
		if (accept) begin
			rd_d_s1             <= regs_q[rd_d_addr];
			rd_s_s1             <= regs_q[rd_s_addr];
			req_s1.req_type     <= req.req_type;
			req_s1.imm_value    <= req.imm_value;
			req_s1.src_index    <= req.src_index;
			req_s1.dst_index    <= req.dst_index;
			ok_d_s1  <= idx_in_range(req.dst_index) && vld_q[rd_d_addr];
			ok_s_s1  <= idx_in_range(req.src_index) && vld_q[rd_s_addr];
			fwd_d_s1 <= wr_en && (req_s1.dst_index == req.dst_index);
			fwd_s_s1 <= wr_en && (req_s1.dst_index == req.src_index);
			fwd_v_s1 <= result;
		end
		if (fire && op_ok) begin
			out_idx_q <= req_s1.dst_index;
			out_val_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire && op_ok) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid         = out_valid_q;
	assign res.written_index = out_idx_q;
	assign res.written_value = out_val_q;

endmodule
